// ----- hdl/mwpo_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the phase oscillator.
// No dependencies; used by the controller, datapath, top level and testbench.
package mwpo_pkg;

    localparam int PHASE_BITS_DEF = 32;
    localparam int POLY_STEPS     = 5;

    // Sine polynomial coefficients, Q4.28
    localparam logic signed [32:0] C0 = 33'sd842614065;
    localparam logic signed [32:0] C1 = -33'sd1378046968;
    localparam logic signed [32:0] C2 = 33'sd651838597;
    localparam logic signed [32:0] C3 = 33'sd116405693;

    localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;

    typedef enum logic [1:0] {
        WAVE_SAW  = 2'd0,
        WAVE_POLY = 2'd1,
        WAVE_PARA = 2'd2,
        WAVE_TRI  = 2'd3
    } t_wave;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_POST,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_X_X,
        MUL_XX_C3,
        MUL_XX_T,
        MUL_X_T,
        MUL_G_G
    } t_mul_sel;

    typedef enum logic [2:0] {
        POST_XX,
        POST_T2,
        POST_T1,
        POST_T0,
        POST_Y,
        POST_PARA
    } t_post_sel;

    typedef struct packed {
        logic      accept;
        logic      setup;
        logic      mul_en;
        logic      post_en;
        logic      emit;
        t_wave     wave;
        t_mul_sel  mul_sel;
        t_post_sel post_sel;
    } t_cmd;

    // Round half up by 2^k, then saturate to Q1.15
    function automatic logic signed [15:0] to_q15(input logic signed [63:0] v, input int k);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< (k - 1))) >>> k;
        if (r > 64'sd32767) begin
            to_q15 = 16'sh7FFF;
        end else if (r < -64'sd32768) begin
            to_q15 = 16'sh8000;
        end else begin
            to_q15 = r[15:0];
        end
    endfunction

endpackage

// ----- hdl/mwpo_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: phase increment in, sample out, waveform config.
// Depends on nothing.
interface mwpo_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] increment;
    modport source (output valid, output increment, input ready);
    modport sink (input valid, input increment, output ready);
endinterface

interface mwpo_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mwpo_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] waveform;
    modport source (output valid, output waveform, input ready);
    modport sink (input valid, input waveform, output ready);
endinterface

// ----- hdl/mwpo_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing controller: handshakes, waveform register and datapath commands.
// Depends on mwpo_pkg.
module mwpo_ctrl
    import mwpo_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_waveform,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    t_wave      r_wave;
    logic       r_out_valid, n_out_valid;
    logic       w_last;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last     = (r_wave != WAVE_POLY) || (r_step == 3'(POLY_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_wave      <= WAVE_POLY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_wave <= t_wave'(i_cfg_waveform);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_step = '0;
                if (r_wave == WAVE_SAW || r_wave == WAVE_TRI) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                    n_step  = r_step + 3'd1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cmd.accept    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.setup     = (r_state == ST_SETUP);
        o_cmd.mul_en    = (r_state == ST_MUL);
        o_cmd.post_en   = (r_state == ST_POST);
        o_cmd.emit      = (r_state == ST_DONE) && w_out_free;
        o_cmd.wave      = r_wave;
        o_cmd.mul_sel   = MUL_G_G;
        o_cmd.post_sel  = POST_PARA;
        if (r_wave == WAVE_POLY) begin
            case (r_step)
                3'd0: begin
                    o_cmd.mul_sel  = MUL_X_X;
                    o_cmd.post_sel = POST_XX;
                end
                3'd1: begin
                    o_cmd.mul_sel  = MUL_XX_C3;
                    o_cmd.post_sel = POST_T2;
                end
                3'd2: begin
                    o_cmd.mul_sel  = MUL_XX_T;
                    o_cmd.post_sel = POST_T1;
                end
                3'd3: begin
                    o_cmd.mul_sel  = MUL_XX_T;
                    o_cmd.post_sel = POST_T0;
                end
                default: begin
                    o_cmd.mul_sel  = MUL_X_T;
                    o_cmd.post_sel = POST_Y;
                end
            endcase
        end
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        o_out_valid = r_out_valid;
    end

endmodule

// ----- hdl/mwpo_datapath.sv -----
`timescale 1ns / 1ps
// Phase accumulator, shared 33x33 multiplier and waveform shaping registers.
// Depends on mwpo_pkg.
module mwpo_datapath
    import mwpo_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_increment,
    input  t_cmd        i_cmd,
    output logic [15:0] o_sample
);

    localparam int UP = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
    localparam int DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

    logic        [PHASE_BITS-1:0]  r_phase;
    logic signed [PHASE_BITS+31:0] w_inc_ext;
    logic signed [PHASE_BITS+31:0] w_inc_sh;
    logic        [PHASE_BITS+31:0] w_phase_ext;
    logic        [31:0]            w_u;

    logic signed [32:0] r_x, r_xx, r_t;
    logic        [30:0] r_g;
    logic        [1:0]  r_quad;
    logic signed [65:0] r_prod;
    logic signed [15:0] r_res;
    logic        [15:0] r_sample;

    logic signed [32:0] w_a, w_b, w_x, w_prod_sh;
    logic        [29:0] w_r;
    logic signed [63:0] w_tri, w_para;

    // Increment scaled to the accumulator width: shifted up, or floored down
    assign w_inc_ext = {{PHASE_BITS{i_increment[31]}}, i_increment};
    assign w_inc_sh  = (PHASE_BITS >= 32) ? (w_inc_ext <<< UP) : (w_inc_ext >>> DN);

    // Top 32 phase bits, zero filled below for narrow accumulators
    assign w_phase_ext = {r_phase, 32'b0};
    assign w_u         = w_phase_ext[PHASE_BITS+31 -: 32];

    assign w_x = {~w_u[31], ~w_u[31], w_u[30:0]};
    assign w_r = w_u[29:0];

    always_comb begin
        case (w_u[31:30])
            2'd0:    w_tri = {34'b0, w_r};
            2'd1:    w_tri = (64'sd1 <<< 30) - {34'b0, w_r};
            2'd2:    w_tri = -{34'b0, w_r};
            default: w_tri = {34'b0, w_r} - (64'sd1 <<< 30);
        endcase
    end

    assign w_para    = r_quad[1] ? (r_prod[63:0] - ONE_Q60) : (ONE_Q60 - r_prod[63:0]);
    assign w_prod_sh = r_prod[63:31];

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_X_X: begin
                w_a = r_x;
                w_b = r_x;
            end
            MUL_XX_C3: begin
                w_a = r_xx;
                w_b = C3;
            end
            MUL_XX_T: begin
                w_a = r_xx;
                w_b = r_t;
            end
            MUL_X_T: begin
                w_a = r_x;
                w_b = r_t;
            end
            default: begin
                w_a = {2'b0, r_g};
                w_b = {2'b0, r_g};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.accept) begin
            r_phase <= r_phase + w_inc_sh[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_x    <= w_x;
            r_quad <= w_u[31:30];
            r_g    <= w_u[30] ? {1'b0, w_r} : (31'd1 << 30) - {1'b0, w_r};
            if (i_cmd.wave == WAVE_SAW) begin
                r_res <= to_q15({{31{w_x[32]}}, w_x}, 16);
            end else begin
                r_res <= to_q15(w_tri, 15);
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_a * w_b;
        end
        if (i_cmd.post_en) begin
            case (i_cmd.post_sel)
                POST_XX: r_xx  <= w_prod_sh;
                POST_T2: r_t   <= C2 - w_prod_sh;
                POST_T1: r_t   <= C1 + w_prod_sh;
                POST_T0: r_t   <= C0 + w_prod_sh;
                POST_Y:  r_res <= to_q15({{31{w_prod_sh[32]}}, w_prod_sh}, 13);
                default: r_res <= to_q15(w_para, 45);
            endcase
        end
        if (i_cmd.emit) begin
            r_sample <= r_res;
        end
    end

    assign o_sample = r_sample;

endmodule

// ----- hdl/multi_waveform_phase_oscillator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the multi-waveform phase oscillator.
// Depends on mwpo_pkg, mwpo_if, mwpo_ctrl and mwpo_datapath.

// Each accepted increment advances a PHASE_BITS-wide phase accumulator (wrapping both
// ways) and yields one Q1.15 sample of the selected waveform: sawtooth, polynomial sine,
// parabolic sine or triangle, rounded half up and saturated. Waveform selection resets
// to the polynomial sine and should only be written while the block is idle. Sawtooth
// and triangle go from setup straight to the output register; the parabolic sine takes
// one product and the polynomial sine its five Horner products through the single shared
// 33x33 multiplier, each passing through a multiply state and a post state. A new request
// is taken once the previous one has reached the output register, so the output may be
// stalled while the next sample is computed.
module multi_waveform_phase_oscillator_unit
    import mwpo_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwpo_in_if.sink    i_in,
    mwpo_cfg_if.sink   i_cfg,
    mwpo_out_if.source o_out
);

    t_cmd w_cmd;

    assign i_cfg.ready = 1'b1;

    mwpo_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_waveform (i_cfg.waveform),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_cmd          (w_cmd)
    );

    mwpo_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_increment (i_in.increment),
        .i_cmd       (w_cmd),
        .o_sample    (o_out.sample)
    );

`ifndef SYNTH
    a_accept_then_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> w_cmd.setup)
        else $error("setup did not follow accepted request");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out.valid || o_out.ready))
        else $error("result emitted over a pending sample");

    a_mul_post_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.mul_en && w_cmd.post_en) && !(w_cmd.accept && w_cmd.mul_en))
        else $error("overlapping datapath commands");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the multi-waveform phase oscillator.
// Depends on mwpo_pkg, the mwpo channel interfaces and multi_waveform_phase_oscillator_unit.
module tb_top;
    import mwpo_pkg::*;

    localparam int PB          = PHASE_BITS_DEF;
    localparam int STEP_UP     = (PB > 32) ? PB - 32 : 0;
    localparam int STEP_DN     = (PB < 32) ? 32 - PB : 0;
    localparam int TIMEOUT     = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 125;

    // Sine polynomial coefficients, Q4.28
    localparam longint K0 = 64'sd842614065;
    localparam longint K1 = -64'sd1378046968;
    localparam longint K2 = 64'sd651838597;
    localparam longint K3 = 64'sd116405693;

    typedef struct packed {
        t_wave       wave;
        logic [31:0] inc;
        logic        known;
        logic [15:0] sample;
    } t_dir_row;

    typedef struct packed {
        t_wave       wave;
        logic [15:0] sample;
    } t_sample_exp;

    logic clk;
    logic rst_n;

    mwpo_in_if  in_ch ();
    mwpo_cfg_if cfg_ch ();
    mwpo_out_if out_ch ();

    multi_waveform_phase_oscillator_unit #(
        .PHASE_BITS(PB)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    logic [63:0] phase_acc;
    t_wave       cur_wave;
    t_sample_exp expected_samples[$];
    int          errors;
    int          cycle_count;
    int          requests_sent;
    int          checked_per_wave[4];
    bit          send_idle;
    bit          recv_idle;
    bit          hold_req;

    // Known rows land the phase on the wrap points and quadrant edges so the expected values are exact
    t_dir_row dir_rows[24] = '{
        '{WAVE_POLY, 32'h00000000, 1'b1, 16'h0000},
        '{WAVE_SAW,  32'h00000000, 1'b1, 16'h8000},
        '{WAVE_SAW,  32'h80000000, 1'b1, 16'h0000},
        '{WAVE_SAW,  32'h7FFFFFFF, 1'b1, 16'h7FFF},
        '{WAVE_SAW,  32'h00000001, 1'b1, 16'h8000},
        '{WAVE_SAW,  32'hFFFFFFFF, 1'b1, 16'h7FFF},
        '{WAVE_TRI,  32'h40000001, 1'b1, 16'h7FFF},
        '{WAVE_TRI,  32'h40000000, 1'b1, 16'h0000},
        '{WAVE_TRI,  32'h40000000, 1'b1, 16'h8000},
        '{WAVE_TRI,  32'h40000000, 1'b1, 16'h0000},
        '{WAVE_TRI,  32'h20000000, 1'b1, 16'h4000},
        '{WAVE_PARA, 32'h20000000, 1'b1, 16'h7FFF},
        '{WAVE_PARA, 32'h40000000, 1'b1, 16'h0000},
        '{WAVE_PARA, 32'h40000000, 1'b1, 16'h8000},
        '{WAVE_PARA, 32'h40000000, 1'b1, 16'h0000},
        '{WAVE_PARA, 32'h12345678, 1'b0, 16'h0000},
        '{WAVE_PARA, 32'hEDCBA988, 1'b0, 16'h0000},
        '{WAVE_POLY, 32'h40000000, 1'b0, 16'h0000},
        '{WAVE_POLY, 32'h80000000, 1'b0, 16'h0000},
        '{WAVE_POLY, 32'h40000000, 1'b0, 16'h0000},
        '{WAVE_POLY, 32'h00123456, 1'b0, 16'h0000},
        '{WAVE_POLY, 32'hFFF00000, 1'b0, 16'h0000},
        '{WAVE_SAW,  32'h55555555, 1'b0, 16'h0000},
        '{WAVE_TRI,  32'hAAAAAAAA, 1'b0, 16'h0000}
    };

    t_wave phase_waves[RAND_PHASES] = '{
        WAVE_SAW, WAVE_POLY, WAVE_PARA, WAVE_TRI, WAVE_POLY, WAVE_TRI, WAVE_SAW, WAVE_PARA
    };

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Round half up by 2^k and clamp to Q1.15
    function automatic logic [15:0] round_to_q15(input longint v, input int k);
        longint q;
        q = (v + (64'sd1 <<< (k - 1))) >>> k;
        if (q > 64'sd32767) return 16'h7FFF;
        if (q < -64'sd32768) return 16'h8000;
        return q[15:0];
    endfunction

    // Advances the phase by one tick and returns the sample of the current waveform
    function automatic logic [15:0] next_sample(input logic [31:0] inc);
        longint      step;
        longint      x;
        longint      xx;
        longint      t;
        longint      g;
        longint      v;
        longint      frac;
        logic [63:0] u64;
        logic [31:0] u;
        logic [1:0]  quad;
        step = (longint'($signed(inc)) <<< STEP_UP) >>> STEP_DN;
        phase_acc = (phase_acc + step) & ((64'd1 << PB) - 64'd1);
        u64 = (phase_acc >> STEP_UP) << STEP_DN;
        u = u64[31:0];
        quad = u[31:30];
        frac = longint'({34'd0, u[29:0]});
        x = longint'({32'd0, u}) - (64'sd1 <<< 31);
        case (cur_wave)
            WAVE_SAW: begin
                return round_to_q15(x, 16);
            end
            WAVE_POLY: begin
                xx = (x * x) >>> 31;
                t = K2 - ((xx * K3) >>> 31);
                t = K1 + ((xx * t) >>> 31);
                t = K0 + ((xx * t) >>> 31);
                return round_to_q15((x * t) >>> 31, 13);
            end
            WAVE_PARA: begin
                g = quad[0] ? frac : (64'sd1 <<< 30) - frac;
                v = quad[1] ? g * g - (64'sd1 <<< 60) : (64'sd1 <<< 60) - g * g;
                return round_to_q15(v, 45);
            end
            default: begin
                case (quad)
                    2'd0:    v = frac;
                    2'd1:    v = (64'sd1 <<< 30) - frac;
                    2'd2:    v = -frac;
                    default: v = frac - (64'sd1 <<< 30);
                endcase
                return round_to_q15(v, 15);
            end
        endcase
    endfunction

    function automatic logic [31:0] random_increment();
        logic [31:0] inc;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: inc = $urandom;
            // audio rates up to 20 kHz at 44.1 kHz, either direction
            4, 5: inc = $urandom_range(1, 20000) * 32'd97391;
            6: inc = $urandom_range(0, 255);
            7: begin
                case ($urandom_range(0, 6))
                    0:       inc = 32'h00000000;
                    1:       inc = 32'h80000000;
                    2:       inc = 32'h7FFFFFFF;
                    3:       inc = 32'hFFFFFFFF;
                    4:       inc = 32'h00000001;
                    5:       inc = 32'h40000000;
                    default: inc = 32'hC0000000;
                endcase
            end
            8: inc = 32'd1 << $urandom_range(0, 31);
            default: inc = 32'h40000000 + $urandom_range(0, 64) - 32;
        endcase
        if ($urandom_range(0, 1) == 1 && inc != 32'h80000000) inc = -inc;
        return inc;
    endfunction

    task automatic send_increment(input logic [31:0] inc, input logic known,
                                  input logic [15:0] known_sample);
        int          gap;
        t_sample_exp exp_item;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.increment <= inc;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        exp_item.wave   = cur_wave;
        exp_item.sample = next_sample(inc);
        if (known) exp_item.sample = known_sample;
        expected_samples.push_back(exp_item);
        requests_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
    endtask

    // Every request yields a result, so an empty queue means the block is idle
    task automatic set_waveform(input t_wave w);
        wait_drained();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.waveform <= w;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        cur_wave = w;
    endtask

    initial begin : stimulus
        int r;
        int p;
        int n;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.increment <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.waveform <= WAVE_POLY;
        phase_acc     = '0;
        cur_wave      = WAVE_POLY;
        errors        = 0;
        requests_sent = 0;
        send_idle     = 1'b1;
        recv_idle     = 1'b1;
        hold_req      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < $size(dir_rows); r++) begin
            if (dir_rows[r].wave != cur_wave) set_waveform(dir_rows[r].wave);
            send_increment(dir_rows[r].inc, dir_rows[r].known, dir_rows[r].sample);
        end

        for (p = 0; p < RAND_PHASES; p++) begin
            set_waveform(phase_waves[p]);
            send_idle = (p % 3 != 0);
            recv_idle = (p % 4 != 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // output side stalls for a long stretch while requests keep coming
                if ((p == 2 || p == 5) && n == 10) hold_req = 1'b1;
                if (p == 4 && n == 60) wait_drained();
                send_increment(random_increment(), 1'b0, 16'h0000);
            end
        end

        wait_drained();
        repeat (30) @(posedge clk);
        $display("Checked %0d samples: saw %0d, poly sine %0d, parabola %0d, triangle %0d",
                 requests_sent, checked_per_wave[WAVE_SAW], checked_per_wave[WAVE_POLY],
                 checked_per_wave[WAVE_PARA], checked_per_wave[WAVE_TRI]);
        $display("Covered wrap in both directions, full-scale clamping, idle gaps and hold-offs");
        if (errors == 0 && expected_samples.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d samples still expected", errors,
                     expected_samples.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : sample_sink
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = recv_idle ? $urandom_range(0, 7) : 0;
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    always @(posedge clk) begin : sample_check
        t_sample_exp exp_item;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_samples.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected sample %h at cycle %0d", out_ch.sample, cycle_count);
                end
            end else begin
                exp_item = expected_samples.pop_front();
                checked_per_wave[exp_item.wave]++;
                if (out_ch.sample !== exp_item.sample) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Sample mismatch (wave %s) at cycle %0d: expected %h, got %h",
                                 exp_item.wave.name(), cycle_count, exp_item.sample,
                                 out_ch.sample);
                    end
                end
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > TIMEOUT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// ----- files.f -----
hdl/mwpo_pkg.sv
hdl/mwpo_if.sv
hdl/mwpo_ctrl.sv
hdl/mwpo_datapath.sv
hdl/multi_waveform_phase_oscillator_unit.sv
test/tb_top.sv
